@@ hdl/integer_square_root_64_unit_assert.svh @@
// Assertion macros for the integer square root unit
`ifndef INTEGER_SQUARE_ROOT_64_UNIT_ASSERT_SVH
`define INTEGER_SQUARE_ROOT_64_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define ISR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ISR_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ISR_ASSERT(label, clk, rst, prop, msg)

`define ISR_ASSERT_RST(label, clk, prop, msg)

`endif

`endif

@@ hdl/isr_pkg.sv @@
// Shared widths and constants for the integer square root unit
`default_nettype none

package isr_pkg;

   localparam int RADICAND_W      = 64;
   localparam int ROOT_W          = 32;
   localparam int STEPS_PER_STAGE = 4;

endpackage

`default_nettype wire

@@ hdl/isr_if.sv @@
// Valid/ready channel interfaces for radicand and root items
`default_nettype none

interface isr_req_if;
   logic                           valid;
   logic                           ready;
   logic [isr_pkg::RADICAND_W-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

interface isr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [isr_pkg::ROOT_W-1:0] root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

@@ hdl/integer_square_root_64_unit.sv @@
// Pipelined floor square root of an unsigned radicand
//
//   channel   dir   payload            handshake
//   req_chan  in    radicand [63:0]    valid/ready
//   rsp_chan  out   root     [31:0]    valid/ready
//
// Each stage registers its partial root, remainder and shifted radicand.
// Each stage settles four root bits with four restoring compare/subtract steps.
// One item enters per cycle; a stalled stage holds and bubbles close up behind it.
// Synchronous reset clears only the stage valid bits.
`default_nettype none

`include "integer_square_root_64_unit_assert.svh"

module integer_square_root_64_unit #(
   parameter int INPUT_WIDTH = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   isr_req_if.sink   req_chan,
   isr_rsp_if.source rsp_chan
);

   localparam int STEPS     = isr_pkg::STEPS_PER_STAGE;
   localparam int USED_BITS = (INPUT_WIDTH + 1) / 2;
   localparam int STAGES    = (USED_BITS + STEPS - 1) / STEPS;
   localparam int PIPE_BITS = STAGES * STEPS;
   localparam int RAD_W     = 2 * PIPE_BITS;
   localparam int REM_W     = PIPE_BITS + 2;
   localparam int OUT_W     = isr_pkg::ROOT_W;

   logic                   valid_w [0:STAGES];
   logic                   ready_w [0:STAGES];
   logic [RAD_W-1:0]       rad_w   [0:STAGES];
   logic [REM_W-1:0]       rem_w   [0:STAGES];
   logic [PIPE_BITS-1:0]   root_w  [0:STAGES];
   logic [INPUT_WIDTH-1:0] rad_masked;

   assign rad_masked = req_chan.radicand[INPUT_WIDTH-1:0];

   assign valid_w[0]     = req_chan.valid;
   assign req_chan.ready = ready_w[0];
   assign rad_w[0]       = RAD_W'(rad_masked);
   assign rem_w[0]       = '0;
   assign root_w[0]      = '0;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      isr_stage #(
         .ROOT_BITS (PIPE_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_w[i]),
         .ready_out (ready_w[i]),
         .rad_in    (rad_w[i]),
         .rem_in    (rem_w[i]),
         .root_in   (root_w[i]),
         .valid_out (valid_w[i+1]),
         .ready_in  (ready_w[i+1]),
         .rad_out   (rad_w[i+1]),
         .rem_out   (rem_w[i+1]),
         .root_out  (root_w[i+1])
      );
   end

   assign ready_w[STAGES] = rsp_chan.ready;
   assign rsp_chan.valid  = valid_w[STAGES];
   assign rsp_chan.root   = OUT_W'(root_w[STAGES]);

   `ISR_ASSERT_RST(a_reset_empties, clock, reset |=> !rsp_chan.valid,
      "result valid after reset")
   `ISR_ASSERT(a_backpressure_full, clock, reset,
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready),
      "input stalled without a stalled result")

endmodule

`default_nettype wire

@@ hdl/isr_stage.sv @@
// One pipeline stage settling a group of root bits by restoring digit steps
`default_nettype none

module isr_stage #(
   parameter int ROOT_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   valid_in,
   output logic                        ready_out,
   input  wire logic [2*ROOT_BITS-1:0] rad_in,
   input  wire logic [ROOT_BITS+1:0]   rem_in,
   input  wire logic [ROOT_BITS-1:0]   root_in,
   output logic                        valid_out,
   input  wire logic                   ready_in,
   output logic [2*ROOT_BITS-1:0]      rad_out,
   output logic [ROOT_BITS+1:0]        rem_out,
   output logic [ROOT_BITS-1:0]        root_out
);

   localparam int STEPS = isr_pkg::STEPS_PER_STAGE;
   localparam int RAD_W = 2 * ROOT_BITS;
   localparam int REM_W = ROOT_BITS + 2;

   logic                 valid_ff;
   logic                 valid_in_d;
   logic [RAD_W-1:0]     rad_ff;
   logic [RAD_W-1:0]     rad_in_d;
   logic [REM_W-1:0]     rem_ff;
   logic [REM_W-1:0]     rem_in_d;
   logic [ROOT_BITS-1:0] root_ff;
   logic [ROOT_BITS-1:0] root_in_d;
   logic [REM_W-1:0]     trial;
   logic [1:0]           pair;

   assign ready_out = !valid_ff || ready_in;
   assign valid_in_d = ready_out ? valid_in : valid_ff;
   assign rad_in_d   = rad_in << (2 * STEPS);

   always_comb begin
      rem_in_d  = rem_in;
      root_in_d = root_in;
      trial     = '0;
      pair      = '0;
      for (int s = 0; s < STEPS; s++) begin
         pair      = rad_in[RAD_W-1-2*s -: 2];
         rem_in_d  = {rem_in_d[REM_W-3:0], pair};
         trial     = {root_in_d, 2'b01};
         root_in_d = {root_in_d[ROOT_BITS-2:0], 1'b0};
         if (rem_in_d >= trial) begin
            rem_in_d     = rem_in_d - trial;
            root_in_d[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_d;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         rad_ff  <= rad_in_d;
         rem_ff  <= rem_in_d;
         root_ff <= root_in_d;
      end
   end

   assign valid_out = valid_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;

endmodule

`default_nettype wire
